@@ src/btss_pkg.sv @@
package btss_pkg;

   // Default number of values held.
   localparam int CAPACITY_DEF = 8;

   // Field widths.
   localparam int VALUE_W     = 32;
   localparam int HELD_W      = 4;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 72;

   // Operation codes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EVICTED   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

   // Top value reported for an empty store.
   localparam logic signed [VALUE_W-1:0] EMPTY_TOP = -32'sd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } ctl_cmd_type;

endpackage

@@ src/btss_ctrl.sv @@
module btss_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output btss_pkg::ctl_cmd_type cmd
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_UPDATE = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // The output register can be loaded when empty or being drained this cycle.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Accept a beat in idle, then commit once the output register is free.
   always_comb begin
      cmd.capture  = 1'b0;
      cmd.commit   = 1'b0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/btss_datapath.sv @@
module btss_datapath #(
   parameter int CAPACITY = btss_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  btss_pkg::ctl_cmd_type              cmd,
   input  logic [btss_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic [btss_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Cell row, kept in descending order: cell 0 holds the largest value.
   logic signed [btss_pkg::VALUE_W-1:0] cell_ff [CAPACITY];
   logic signed [btss_pkg::VALUE_W-1:0] cell_in [CAPACITY];
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CAPACITY-1:0] gt_ff, eq_ff;
   logic [CAPACITY-1:0] gt_in, eq_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic                                op_ff;
   logic signed [btss_pkg::VALUE_W-1:0] value_ff;
   logic signed [btss_pkg::VALUE_W-1:0] req_value;
   logic                                duplicate;
   logic                                full;
   logic                                empty;
   logic [btss_pkg::STATUS_W-1:0]       status;
   logic signed [btss_pkg::VALUE_W-1:0] evicted;
   logic signed [btss_pkg::VALUE_W-1:0] top;
   logic [btss_pkg::RSP_TDATA_W-1:0]    rsp_ff, rsp_in;

   assign req_value = req_tdata[btss_pkg::VALUE_W:1];

   // Per-cell compare of the incoming value against each held value.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         gt_in[i] = valid_ff[i] && (cell_ff[i] > req_value);
         eq_in[i] = valid_ff[i] && (cell_ff[i] == req_value);
      end
   end

   assign duplicate = |eq_ff;
   assign full      = valid_ff[CAPACITY-1];
   assign empty     = !valid_ff[0];

   // Next contents of each cell: shift toward the tail on insert, toward the head on remove.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [btss_pkg::VALUE_W-1:0] ins_val;
      logic signed [btss_pkg::VALUE_W-1:0] rem_val;
      logic                                ins_vld;
      logic                                rem_vld;

      if (i == 0) begin : g_head
         assign ins_val = gt_ff[i] ? cell_ff[i] : value_ff;
         assign ins_vld = 1'b1;
      end else begin : g_body
         assign ins_val = gt_ff[i]   ? cell_ff[i] :
                          gt_ff[i-1] ? value_ff   : cell_ff[i-1];
         assign ins_vld = valid_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign rem_val = cell_ff[i];
         assign rem_vld = 1'b0;
      end else begin : g_mid
         assign rem_val = cell_ff[i+1];
         assign rem_vld = valid_ff[i+1];
      end

      always_comb begin
         cell_in[i]  = cell_ff[i];
         valid_in[i] = valid_ff[i];
         if (op_ff == btss_pkg::OP_INSERT) begin
            if (!duplicate) begin
               cell_in[i] = ins_val;
               if (!full) begin
                  valid_in[i] = ins_vld;
               end
            end
         end else if (!empty) begin
            cell_in[i]  = rem_val;
            valid_in[i] = rem_vld;
         end
      end
   end

   // Status, evicted value and count for the operation being committed.
   always_comb begin
      status   = btss_pkg::STATUS_OK;
      evicted  = '0;
      count_in = count_ff;
      if (op_ff == btss_pkg::OP_INSERT) begin
         if (duplicate) begin
            status = btss_pkg::STATUS_DUPLICATE;
         end else if (full) begin
            status  = btss_pkg::STATUS_EVICTED;
            evicted = gt_ff[CAPACITY-1] ? value_ff : cell_ff[CAPACITY-1];
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (empty) begin
         status = btss_pkg::STATUS_EMPTY;
      end else begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign top    = valid_in[0] ? cell_in[0] : btss_pkg::EMPTY_TOP;
   assign rsp_in = {2'b00, evicted, status, btss_pkg::HELD_W'(count_in), top};
   assign rsp_tdata = rsp_ff;

   // Control state: valid bits and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_tdata[0];
         value_ff <= req_value;
         gt_ff    <= gt_in;
         eq_ff    <= eq_in;
      end
      if (cmd.commit) begin
         cell_ff <= cell_in;
         rsp_ff  <= rsp_in;
      end
   end

endmodule

@@ src/bounded_top_n_sorted_set_top.sv @@
// A request beat is accepted in idle, with its compares over the cell row captured;
// the shift is committed and its result registered once the output register is free.
// No new request is taken until the previous one has been committed.
// A request is accepted while a finished result still waits in the output register.
// Reset (synchronous, active high) empties the store and drops any pending result.
module bounded_top_n_sorted_set_top #(
   parameter int CAPACITY = btss_pkg::CAPACITY_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // op [0], new_value [32:1], zero [39:33]
   input  logic [btss_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // top_value [31:0], held_count [35:32], status [37:36], evicted_value [69:38], zero [71:70]
   output logic [btss_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   btss_pkg::ctl_cmd_type cmd;

   btss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   btss_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ src/btss_checker.sv @@
module btss_checker #(
   parameter int CAPACITY = btss_pkg::CAPACITY_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [btss_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic signed [btss_pkg::VALUE_W-1:0] top;
   logic [btss_pkg::HELD_W-1:0]         held;
   logic [btss_pkg::STATUS_W-1:0]       status;
   logic signed [btss_pkg::VALUE_W-1:0] evicted;

   assign top     = rsp_tdata[31:0];
   assign held    = rsp_tdata[35:32];
   assign status  = rsp_tdata[37:36];
   assign evicted = rsp_tdata[69:38];

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // A request beat is never taken in the cycle right after another one.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request beats taken in consecutive cycles");

   // A remove on an empty store reports an empty store.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == btss_pkg::STATUS_EMPTY |->
         held == '0 && top == btss_pkg::EMPTY_TOP)
      else $error("remove on empty reports a non-empty store");

   // Only an eviction carries an evicted value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status != btss_pkg::STATUS_EVICTED |-> evicted == '0)
      else $error("evicted value without eviction");

   // An eviction only happens on a full store.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == btss_pkg::STATUS_EVICTED |->
         held == btss_pkg::HELD_W'(CAPACITY))
      else $error("eviction from a store that is not full");

endmodule

bind bounded_top_n_sorted_set_top btss_checker #(.CAPACITY(CAPACITY)) u_btss_checker (.*);
